[design/sms_pkg.sv]
`timescale 1ns / 1ps

package sms_pkg;

  localparam int WORD_W    = 32;
  localparam int MEM_WORDS = 4096;
  localparam int ADDR_W    = $clog2(MEM_WORDS);
  localparam int PTR_W     = ADDR_W + 1;
  localparam int CAP_W     = 10;
  localparam int DIV_CNT_W = $clog2(WORD_W + 1);

  localparam logic [PTR_W-1:0]  MEM_LIMIT     = PTR_W'(MEM_WORDS);
  localparam logic [PTR_W-1:0]  CODE_START    = PTR_W'(0);
  localparam logic [PTR_W-1:0]  STACK_START   = PTR_W'(3072);
  localparam logic [PTR_W-1:0]  STACK_END     = PTR_W'(4032);
  localparam logic [PTR_W-1:0]  STACK_SPAN    = STACK_END - STACK_START;
  localparam logic [ADDR_W-1:0] KEYBOARD_ADDR = ADDR_W'(4095);

  typedef enum logic [1:0] {
    KIND_STEP,
    KIND_WRITE,
    KIND_KEYBOARD,
    KIND_RESTART
  } kind_t;

  typedef enum logic [3:0] {
    STAT_OK,
    STAT_HALTED,
    STAT_IP_RANGE,
    STAT_TRUNCATED,
    STAT_OVERFLOW,
    STAT_UNDERFLOW,
    STAT_DIV_ZERO,
    STAT_MOD_ZERO,
    STAT_ADDR_RANGE,
    STAT_JUMP_RANGE,
    STAT_BAD_OPCODE
  } status_t;

  typedef enum logic [4:0] {
    OP_HALT,
    OP_PUSHI,
    OP_POP,
    OP_DUP,
    OP_SWAP,
    OP_NEG,
    OP_OVER,
    OP_ADD,
    OP_SUB,
    OP_MUL,
    OP_DIV,
    OP_MOD,
    OP_CMP_EQ,
    OP_CMP_LT,
    OP_CMP_GT,
    OP_PRINT,
    OP_LOAD,
    OP_STORE,
    OP_STORE_IND,
    OP_JMP,
    OP_JZ,
    OP_JNZ
  } opcode_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_FETCH,
    S_DECODE,
    S_OPERAND,
    S_LOADW,
    S_TOS,
    S_SECOND,
    S_SWAP2,
    S_DIVIDE,
    S_PUSH,
    S_FINISH
  } state_t;

endpackage

[design/sms_ram.sv]
`timescale 1ns / 1ps

module sms_ram #(
  parameter int AW = 12,
  parameter int DW = 32
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[design/sms_div.sv]
`timescale 1ns / 1ps

module sms_div import sms_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [WORD_W-1:0] dividend,
  input  logic [WORD_W-1:0] divisor,
  output logic              done,
  output logic [WORD_W-1:0] quot,
  output logic [WORD_W-1:0] rem
);

  logic                 busy;
  logic [DIV_CNT_W-1:0] cnt;
  logic [WORD_W-1:0]    q;
  logic [WORD_W-1:0]    r;
  logic [WORD_W-1:0]    d;
  logic                 neg_q;
  logic                 neg_r;
  logic [WORD_W:0]      trial;
  logic [WORD_W:0]      diff;
  logic                 fits;

  assign trial = {r, q[WORD_W-1]};
  assign diff  = trial - {1'b0, d};
  assign fits  = trial >= {1'b0, d};
  assign done  = busy && (cnt == '0);
  assign quot  = neg_q ? (WORD_W'(0) - q) : q;
  assign rem   = neg_r ? (WORD_W'(0) - r) : r;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= DIV_CNT_W'(WORD_W);
    end else if (busy) begin
      if (cnt == '0) begin
        busy <= 1'b0;
      end else begin
        cnt <= cnt - DIV_CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q     <= dividend[WORD_W-1] ? (WORD_W'(0) - dividend) : dividend;
      d     <= divisor[WORD_W-1] ? (WORD_W'(0) - divisor) : divisor;
      r     <= '0;
      neg_q <= dividend[WORD_W-1] ^ divisor[WORD_W-1];
      neg_r <= dividend[WORD_W-1];
    end else if (busy && (cnt != '0)) begin
      r <= fits ? diff[WORD_W-1:0] : trial[WORD_W-1:0];
      q <= {q[WORD_W-2:0], fits};
    end
  end

endmodule

[design/stack_machine_step_core.sv]
`timescale 1ns / 1ps

// Channel   Direction  Handshake             Payload
// in        input      in_valid / in_stall   kind, cell_address, cell_data
// out       output     out_valid / out_stall status, print_valid, print_value,
//                                            next_ip, stack_top
// cfg       input      cfg_write_en          cfg_write_data
//
// A memory write, keyboard or restart word gives its result in the cycle after it is taken.
// A step word gives its result once the single read port of the word memory has fetched the
// opcode, the operand, a loaded word or up to two stack entries in turn; DIV and MOD also wait
// on the one-bit-per-cycle divider. The next word can be taken in the cycle after a step result
// is loaded.
// After reset the word memory is cleared at one word per cycle, all 4096 words, with in stalled.
// A finished step result waits in S_FINISH while out is stalled.

module stack_machine_step_core import sms_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [1:0]               kind,
  input  logic [ADDR_W-1:0]        cell_address,
  input  logic signed [WORD_W-1:0] cell_data,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [3:0]               status,
  output logic                     print_valid,
  output logic signed [WORD_W-1:0] print_value,
  output logic [PTR_W-1:0]         next_ip,
  output logic [PTR_W-1:0]         stack_top,
  input  logic                     cfg_write_en,
  input  logic [CAP_W-1:0]         cfg_write_data
);

  state_t              state;
  state_t              state_next;
  logic [ADDR_W-1:0]   clr_cnt;
  logic [PTR_W-1:0]    ip;
  logic [PTR_W-1:0]    sp;
  logic [CAP_W-1:0]    cap;
  opcode_t             op_reg;
  logic [WORD_W-1:0]   a_reg;
  logic [WORD_W-1:0]   addr_reg;
  status_t             res_status;
  logic                res_pv;
  logic [WORD_W-1:0]   res_pval;

  logic                mem_we;
  logic [ADDR_W-1:0]   mem_waddr;
  logic [WORD_W-1:0]   mem_wdata;
  logic [ADDR_W-1:0]   mem_raddr;
  logic [WORD_W-1:0]   mem_rdata;

  logic                div_start;
  logic                div_done;
  logic [WORD_W-1:0]   div_quot;
  logic [WORD_W-1:0]   div_rem;

  logic                in_acc;
  logic                out_free;
  logic                out_load;
  kind_t               kind_in;
  opcode_t             op_in;
  logic                op_ok;
  logic [PTR_W-1:0]    sp_m1;
  logic [PTR_W-1:0]    sp_m2;
  logic [PTR_W-1:0]    lim;
  logic                ip_out;
  logic                sp_empty;
  logic                sp_one;
  logic                sp_full;
  logic                rd_bad;
  logic                addr_bad;
  logic                top_bad;
  logic                jump_taken;
  logic [WORD_W-1:0]   alu;

  sms_ram #(.AW(ADDR_W), .DW(WORD_W)) u_ram (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  sms_div u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .dividend(mem_rdata),
    .divisor (a_reg),
    .done    (div_done),
    .quot    (div_quot),
    .rem     (div_rem)
  );

  assign kind_in    = kind_t'(kind);
  assign in_acc     = in_valid && !in_stall;
  assign out_free   = !out_valid || !out_stall;
  assign out_load   = ((state == S_IDLE) && in_acc && (kind_in != KIND_STEP)) ||
                      ((state == S_FINISH) && out_free);
  assign op_in      = opcode_t'(mem_rdata[4:0]);
  assign op_ok      = (mem_rdata[WORD_W-1:5] == '0) && (mem_rdata[4:0] <= OP_JNZ);
  assign sp_m1      = sp - PTR_W'(1);
  assign sp_m2      = sp - PTR_W'(2);
  assign lim        = ((cap != '0) && (PTR_W'(cap) <= STACK_SPAN)) ?
                      (STACK_START + PTR_W'(cap)) : STACK_END;
  assign ip_out     = ip >= MEM_LIMIT;
  assign sp_empty   = sp <= STACK_START;
  assign sp_one     = sp == (STACK_START + PTR_W'(1));
  assign sp_full    = sp >= lim;
  assign rd_bad     = mem_rdata[WORD_W-1:ADDR_W] != '0;
  assign addr_bad   = addr_reg[WORD_W-1:ADDR_W] != '0;
  assign top_bad    = a_reg[WORD_W-1:ADDR_W] != '0;
  assign jump_taken = (op_reg == OP_JZ) == (mem_rdata == '0);

  always_comb begin
    unique case (op_reg) inside
      OP_ADD:    alu = mem_rdata + a_reg;
      OP_SUB:    alu = mem_rdata - a_reg;
      OP_MUL:    alu = WORD_W'(mem_rdata * a_reg);
      OP_CMP_EQ: alu = WORD_W'(mem_rdata == a_reg);
      OP_CMP_LT: alu = WORD_W'($signed(mem_rdata) < $signed(a_reg));
      OP_CMP_GT: alu = WORD_W'($signed(mem_rdata) > $signed(a_reg));
      default:   alu = '0;
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        if (clr_cnt == ADDR_W'(MEM_WORDS - 1)) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_acc && (kind_in == KIND_STEP)) state_next = S_FETCH;
      end
      S_FETCH: begin
        state_next = ip_out ? S_FINISH : S_DECODE;
      end
      S_DECODE: begin
        state_next = S_FINISH;
        if (op_ok) begin
          unique case (op_in) inside
            OP_PUSHI, OP_LOAD, OP_STORE, OP_JMP, OP_JZ, OP_JNZ:
              state_next = ip_out ? S_FINISH : S_OPERAND;
            OP_DUP, OP_NEG, OP_PRINT:
              state_next = sp_empty ? S_FINISH : S_TOS;
            OP_SWAP, OP_OVER, [OP_ADD:OP_CMP_GT], OP_STORE_IND:
              state_next = (sp_empty || sp_one) ? S_FINISH : S_TOS;
            default: state_next = S_FINISH;
          endcase
        end
      end
      S_OPERAND: begin
        unique case (op_reg) inside
          OP_PUSHI:     state_next = S_PUSH;
          OP_LOAD:      state_next = rd_bad ? S_FINISH : S_LOADW;
          OP_STORE:     state_next = (rd_bad || sp_empty) ? S_FINISH : S_TOS;
          OP_JZ, OP_JNZ: state_next = sp_empty ? S_FINISH : S_TOS;
          default:      state_next = S_FINISH;
        endcase
      end
      S_LOADW: state_next = S_PUSH;
      S_TOS: begin
        unique case (op_reg) inside
          OP_SWAP, OP_OVER, [OP_ADD:OP_CMP_GT], OP_STORE_IND: state_next = S_SECOND;
          default: state_next = S_FINISH;
        endcase
      end
      S_SECOND: begin
        unique case (op_reg) inside
          OP_SWAP:        state_next = S_SWAP2;
          OP_OVER:        state_next = S_PUSH;
          OP_STORE_IND:   state_next = S_FINISH;
          OP_DIV, OP_MOD: state_next = (a_reg == '0) ? S_FINISH : S_DIVIDE;
          default:        state_next = S_PUSH;
        endcase
      end
      S_SWAP2:  state_next = S_FINISH;
      S_DIVIDE: state_next = div_done ? S_PUSH : S_DIVIDE;
      S_PUSH:   state_next = S_FINISH;
      S_FINISH: state_next = out_free ? S_IDLE : S_FINISH;
      default:  state_next = S_IDLE;
    endcase
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = sp[ADDR_W-1:0];
    mem_wdata = a_reg;
    mem_raddr = sp_m1[ADDR_W-1:0];
    div_start = 1'b0;
    in_stall  = (state != S_IDLE) || ((kind_in != KIND_STEP) && out_valid && out_stall);
    unique case (state)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_cnt;
        mem_wdata = '0;
      end
      S_IDLE: begin
        if (in_acc && (kind_in == KIND_WRITE)) begin
          mem_we    = 1'b1;
          mem_waddr = cell_address;
          mem_wdata = cell_data;
        end else if (in_acc && (kind_in == KIND_KEYBOARD)) begin
          mem_we    = 1'b1;
          mem_waddr = KEYBOARD_ADDR;
          mem_wdata = cell_data;
        end
      end
      S_FETCH: mem_raddr = ip[ADDR_W-1:0];
      S_DECODE: begin
        if (op_ok) begin
          unique case (op_in) inside
            OP_PUSHI, OP_LOAD, OP_STORE, OP_JMP, OP_JZ, OP_JNZ:
              mem_raddr = ip[ADDR_W-1:0];
            default: mem_raddr = sp_m1[ADDR_W-1:0];
          endcase
        end
      end
      S_OPERAND: begin
        if (op_reg == OP_LOAD) mem_raddr = mem_rdata[ADDR_W-1:0];
      end
      S_TOS: begin
        mem_raddr = sp_m2[ADDR_W-1:0];
        unique case (op_reg) inside
          OP_DUP: begin
            mem_we    = (sp_m1 < lim) && !sp_full;
            mem_waddr = sp[ADDR_W-1:0];
            mem_wdata = mem_rdata;
          end
          OP_NEG: begin
            mem_we    = 1'b1;
            mem_waddr = sp_m1[ADDR_W-1:0];
            mem_wdata = WORD_W'(0) - mem_rdata;
          end
          OP_STORE: begin
            mem_we    = 1'b1;
            mem_waddr = addr_reg[ADDR_W-1:0];
            mem_wdata = mem_rdata;
          end
          default: mem_we = 1'b0;
        endcase
      end
      S_SECOND: begin
        unique case (op_reg) inside
          OP_SWAP: begin
            mem_we    = 1'b1;
            mem_waddr = sp_m1[ADDR_W-1:0];
            mem_wdata = mem_rdata;
          end
          OP_STORE_IND: begin
            mem_we    = !top_bad;
            mem_waddr = a_reg[ADDR_W-1:0];
            mem_wdata = mem_rdata;
          end
          OP_DIV, OP_MOD: div_start = a_reg != '0;
          default: mem_we = 1'b0;
        endcase
      end
      S_SWAP2: begin
        mem_we    = 1'b1;
        mem_waddr = sp_m2[ADDR_W-1:0];
        mem_wdata = a_reg;
      end
      S_PUSH: mem_we = !sp_full;
      default: mem_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_cnt   <= '0;
      ip        <= CODE_START;
      sp        <= STACK_START;
      cap       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_write_en) cap <= cfg_write_data;
      out_valid <= out_load || (out_valid && out_stall);
      unique case (state)
        S_CLEAR: clr_cnt <= clr_cnt + ADDR_W'(1);
        S_IDLE: begin
          if (in_acc && (kind_in == KIND_RESTART)) begin
            ip <= CODE_START;
            sp <= STACK_START;
          end
        end
        S_FETCH: begin
          if (!ip_out) ip <= ip + PTR_W'(1);
        end
        S_DECODE: begin
          if (op_ok) begin
            unique case (op_in) inside
              OP_PUSHI, OP_LOAD, OP_STORE, OP_JMP, OP_JZ, OP_JNZ: begin
                if (!ip_out) ip <= ip + PTR_W'(1);
              end
              OP_POP: begin
                if (!sp_empty) sp <= sp_m1;
              end
              [OP_ADD:OP_CMP_GT], OP_STORE_IND: begin
                if (sp_one) sp <= STACK_START;
              end
              default: sp <= sp;
            endcase
          end
        end
        S_OPERAND: begin
          if ((op_reg == OP_JMP) && !rd_bad) ip <= mem_rdata[PTR_W-1:0];
        end
        S_TOS: begin
          unique case (op_reg) inside
            OP_DUP: begin
              if (sp_m1 >= lim) sp <= sp_m1;
              else if (!sp_full) sp <= sp + PTR_W'(1);
            end
            OP_PRINT, OP_STORE: sp <= sp_m1;
            OP_JZ, OP_JNZ: begin
              sp <= sp_m1;
              if (jump_taken && !addr_bad) ip <= addr_reg[PTR_W-1:0];
            end
            default: sp <= sp;
          endcase
        end
        S_SECOND: begin
          unique case (op_reg) inside
            [OP_ADD:OP_CMP_GT], OP_STORE_IND: sp <= sp_m2;
            default: sp <= sp;
          endcase
        end
        S_PUSH: begin
          if (!sp_full) sp <= sp + PTR_W'(1);
        end
        default: sp <= sp;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        res_status <= STAT_OK;
        res_pv     <= 1'b0;
        res_pval   <= '0;
        if (in_acc && (kind_in != KIND_STEP)) begin
          status      <= STAT_OK;
          print_valid <= 1'b0;
          print_value <= '0;
          next_ip     <= (kind_in == KIND_RESTART) ? CODE_START : ip;
          stack_top   <= (kind_in == KIND_RESTART) ? STACK_START : sp;
        end
      end
      S_FETCH: begin
        if (ip_out) res_status <= STAT_IP_RANGE;
      end
      S_DECODE: begin
        op_reg <= op_in;
        if (!op_ok) begin
          res_status <= STAT_BAD_OPCODE;
        end else begin
          unique case (op_in) inside
            OP_HALT: res_status <= STAT_HALTED;
            OP_PUSHI, OP_LOAD, OP_STORE, OP_JMP, OP_JZ, OP_JNZ: begin
              if (ip_out) res_status <= STAT_TRUNCATED;
            end
            OP_POP, OP_DUP, OP_NEG, OP_PRINT: begin
              if (sp_empty) res_status <= STAT_UNDERFLOW;
            end
            default: begin
              if (sp_empty || sp_one) res_status <= STAT_UNDERFLOW;
            end
          endcase
        end
      end
      S_OPERAND: begin
        addr_reg <= mem_rdata;
        a_reg    <= mem_rdata;
        unique case (op_reg) inside
          OP_LOAD: begin
            if (rd_bad) res_status <= STAT_ADDR_RANGE;
          end
          OP_STORE: begin
            if (rd_bad) res_status <= STAT_ADDR_RANGE;
            else if (sp_empty) res_status <= STAT_UNDERFLOW;
          end
          OP_JMP: begin
            if (rd_bad) res_status <= STAT_JUMP_RANGE;
          end
          OP_JZ, OP_JNZ: begin
            if (sp_empty) res_status <= STAT_UNDERFLOW;
          end
          default: res_pv <= 1'b0;
        endcase
      end
      S_LOADW: a_reg <= mem_rdata;
      S_TOS: begin
        a_reg <= mem_rdata;
        unique case (op_reg) inside
          OP_DUP: begin
            if ((sp_m1 >= lim) || sp_full) res_status <= STAT_OVERFLOW;
          end
          OP_PRINT: begin
            res_pv   <= 1'b1;
            res_pval <= mem_rdata;
          end
          OP_JZ, OP_JNZ: begin
            if (jump_taken && addr_bad) res_status <= STAT_JUMP_RANGE;
          end
          default: res_pv <= 1'b0;
        endcase
      end
      S_SECOND: begin
        unique case (op_reg) inside
          OP_OVER: a_reg <= mem_rdata;
          OP_STORE_IND: begin
            if (top_bad) res_status <= STAT_ADDR_RANGE;
          end
          OP_DIV: begin
            if (a_reg == '0) res_status <= STAT_DIV_ZERO;
          end
          OP_MOD: begin
            if (a_reg == '0) res_status <= STAT_MOD_ZERO;
          end
          OP_SWAP: a_reg <= a_reg;
          default: a_reg <= alu;
        endcase
      end
      S_DIVIDE: begin
        if (div_done) a_reg <= (op_reg == OP_DIV) ? div_quot : div_rem;
      end
      S_PUSH: begin
        if (sp_full) res_status <= STAT_OVERFLOW;
      end
      S_FINISH: begin
        if (out_free) begin
          status      <= res_status;
          print_valid <= res_pv;
          print_value <= res_pval;
          next_ip     <= ip;
          stack_top   <= sp;
        end
      end
      default: res_pv <= res_pv;
    endcase
  end

  a_quick_result: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && (kind_in != KIND_STEP)) |=> out_valid)
    else $error("non-step word gave no result in the next cycle");

  a_stack_floor: assert property (@(posedge clk) disable iff (rst)
    (sp >= STACK_START))
    else $error("stack pointer fell below the stack base");

  a_clear_blocks: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR) |-> (in_stall && !out_valid))
    else $error("word taken or result shown during memory clear");

endmodule
